// ===== hdl/pgg_pkg.sv =====
// Shared types, constants and helper functions of the polar Gaussian pair generator.
package pgg_pkg;

   localparam int SEED_W          = 27;
   localparam int NORM_W          = 32;
   localparam int STAT_W          = 2;
   localparam int TRY_W           = 16;
   localparam int SEED_DIGITS     = 9;
   localparam int LOG_STEPS       = 30;
   localparam int INT_DIV_STEPS   = 60;
   localparam int RATIO_BITS      = 60;

   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FAIL  = 2'd2;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
   localparam logic [OP_W-1:0] OP_SETUP   = 5'd2;
   localparam logic [OP_W-1:0] OP_SQX     = 5'd3;
   localparam logic [OP_W-1:0] OP_DIV_R   = 5'd4;
   localparam logic [OP_W-1:0] OP_DIV_D   = 5'd5;
   localparam logic [OP_W-1:0] OP_TAKE_X  = 5'd6;
   localparam logic [OP_W-1:0] OP_ABS     = 5'd7;
   localparam logic [OP_W-1:0] OP_SQA     = 5'd8;
   localparam logic [OP_W-1:0] OP_SQB     = 5'd9;
   localparam logic [OP_W-1:0] OP_SUM     = 5'd10;
   localparam logic [OP_W-1:0] OP_CHK     = 5'd11;
   localparam logic [OP_W-1:0] OP_NORM    = 5'd12;
   localparam logic [OP_W-1:0] OP_DIV_M   = 5'd13;
   localparam logic [OP_W-1:0] OP_LOGINIT = 5'd14;
   localparam logic [OP_W-1:0] OP_LOGSQ   = 5'd15;
   localparam logic [OP_W-1:0] OP_LOGUPD  = 5'd16;
   localparam logic [OP_W-1:0] OP_WLO     = 5'd17;
   localparam logic [OP_W-1:0] OP_WHI     = 5'd18;
   localparam logic [OP_W-1:0] OP_WSUM    = 5'd19;
   localparam logic [OP_W-1:0] OP_SQRT_W  = 5'd20;
   localparam logic [OP_W-1:0] OP_TAKE_G  = 5'd21;
   localparam logic [OP_W-1:0] OP_DIV_A   = 5'd22;
   localparam logic [OP_W-1:0] OP_SQRT_C  = 5'd23;
   localparam logic [OP_W-1:0] OP_MUL_C   = 5'd24;
   localparam logic [OP_W-1:0] OP_MAG_A   = 5'd25;
   localparam logic [OP_W-1:0] OP_DIV_B   = 5'd26;
   localparam logic [OP_W-1:0] OP_MAG_B   = 5'd27;
   localparam logic [OP_W-1:0] OP_PUBLISH = 5'd28;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [STAT_W-1:0] code;
   } pgg_cmd_type;

   typedef struct packed {
      logic seed_bad;
      logic accept;
      logic norm_done;
      logic m_one;
      logic div_done;
      logic sqrt_done;
   } pgg_stat_type;

   function automatic logic [63:0] pow10(input logic [4:0] p);
      logic [63:0] v;
      case (p)
         5'd0:    v = 64'd1;
         5'd1:    v = 64'd10;
         5'd2:    v = 64'd100;
         5'd3:    v = 64'd1000;
         5'd4:    v = 64'd10000;
         5'd5:    v = 64'd100000;
         5'd6:    v = 64'd1000000;
         5'd7:    v = 64'd10000000;
         5'd8:    v = 64'd100000000;
         5'd9:    v = 64'd1000000000;
         5'd10:   v = 64'd10000000000;
         5'd11:   v = 64'd100000000000;
         5'd12:   v = 64'd1000000000000;
         5'd13:   v = 64'd10000000000000;
         5'd14:   v = 64'd100000000000000;
         5'd15:   v = 64'd1000000000000000;
         5'd16:   v = 64'd10000000000000000;
         5'd17:   v = 64'd100000000000000000;
         5'd18:   v = 64'd1000000000000000000;
         default: v = 64'd0;
      endcase
      return v;
   endfunction

   // number of decimal digits; zero gives zero
   function automatic logic [3:0] digit_count(input logic [SEED_W-1:0] s);
      logic [3:0] k;
      k = 4'd0;
      for (int i = 0; i < SEED_DIGITS; i++) begin
         if ({37'd0, s} >= pow10(5'(i))) k = k + 4'd1;
      end
      return k;
   endfunction

endpackage

// ===== hdl/polar_gaussian_pair_generator.sv =====
// Top level of the polar Gaussian pair generator: controller, datapath and checks.
// Flow: a seed out of range goes from setup straight to the result. Otherwise setup and one
// warm-up middle-square step (two 60-bit divider passes) come first, then one step per try
// plus the checks, and an accepted try goes on through normalise shifts, a 30-step log,
// three root passes and two ratio divides. One request in flight.
// Reset: synchronous, active high; clears the controller state, result valid and unit handshakes only.
module polar_gaussian_pair_generator
   import pgg_pkg::*;
#(
   parameter int MAX_DIGITS = 8,
   parameter int MAX_TRIES  = 1000,
   parameter int FRAC_BITS  = 26
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SEED_W-1:0]        req_seed,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [NORM_W-1:0] rsp_first_normal,
   output logic signed [NORM_W-1:0] rsp_second_normal,
   output logic [STAT_W-1:0]        rsp_status
);

   pgg_cmd_type  cmd;
   pgg_stat_type stat;

   // controller decides the order of work; the datapath only executes commands
   // a new request is taken while the previous result still waits at the output
   pgg_ctrl #(
      .MAX_TRIES (MAX_TRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // result registers live in the datapath and are loaded on publish
   pgg_dp #(
      .MAX_DIGITS (MAX_DIGITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_seed          (req_seed),
      .stat              (stat),
      .rsp_first_normal  (rsp_first_normal),
      .rsp_second_normal (rsp_second_normal),
      .rsp_status        (rsp_status)
   );

`ifndef ASSERT_OFF
   // an accepted request keeps the input side closed until its work is done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken but input not closed");

   // only the three defined status codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE || rsp_status == ST_FAIL))
      else $error("undefined status code on result");

   // a failed request carries zero deviates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_first_normal == '0 && rsp_second_normal == '0))
      else $error("non-zero deviates on failed request");
`endif

endmodule

// ===== hdl/pgg_div.sv =====
// Iterative restoring divider, one quotient bit per cycle after a leading compare step.
module pgg_div
   import pgg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] rem_init,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   input  logic [5:0]  count,
   output logic [63:0] quo,
   output logic [63:0] rem,
   output logic        done
);

   logic        busy_ff, busy_in;
   logic        pre_ff, pre_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] shf_ff, shf_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [63:0] trial;

   assign trial = {rem_ff[62:0], shf_ff[63]};

   always_comb begin
      busy_in = busy_ff;
      pre_in  = pre_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shf_in  = shf_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         pre_in  = 1'b1;
         cnt_in  = count;
         rem_in  = rem_init;
         quo_in  = 64'd0;
         shf_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff && pre_ff) begin
         // leading step: covers a remainder start equal to the divisor
         pre_in = 1'b0;
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = 64'd1;
         end
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         shf_in = {shf_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (trial >= dsr_ff) begin
            rem_in = trial - dsr_ff;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pre_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pre_ff  <= pre_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      shf_ff <= shf_in;
      dsr_ff <= dsr_in;
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

// ===== hdl/pgg_sqrt.sv =====
// Bit-pair integer square root, one result bit per cycle.
module pgg_sqrt
   import pgg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic [31:0] root,
   output logic        done
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] t;

   assign t = r_ff + b_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = value;
         r_in    = 64'd0;
         b_in    = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (v_ff >= t) begin
            v_in = v_ff - t;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign root = r_ff[31:0];
   assign done = done_ff;

endmodule

// ===== hdl/pgg_dp.sv =====
// Datapath: working registers, shared multiplier, divider and square-root units.
module pgg_dp
   import pgg_pkg::*;
#(
   parameter int MAX_DIGITS = 8,
   parameter int FRAC_BITS  = 26
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  pgg_cmd_type              cmd,
   input  logic [SEED_W-1:0]        req_seed,
   output pgg_stat_type             stat,
   output logic signed [NORM_W-1:0] rsp_first_normal,
   output logic signed [NORM_W-1:0] rsp_second_normal,
   output logic [STAT_W-1:0]        rsp_status
);

   localparam int MAG_SHIFT = 58 - FRAC_BITS;

   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [29:0]       dd_ff, dd_in;
   logic [13:0]       rr_ff, rr_in;
   logic [59:0]       den_ff, den_in;
   logic [29:0]       x1_ff, x1_in;
   logic [29:0]       x2_ff, x2_in;
   logic [29:0]       aa_ff, aa_in;
   logic [29:0]       ab_ff, ab_in;
   logic              na_ff, na_in;
   logic              nb_ff, nb_in;
   logic [63:0]       prod_ff, prod_in;
   logic [59:0]       sa_ff, sa_in;
   logic [59:0]       sb_ff, sb_in;
   logic [60:0]       num_ff, num_in;
   logic [60:0]       n_ff, n_in;
   logic [5:0]        e_ff, e_in;
   logic [30:0]       y_ff, y_in;
   logic [30:0]       fr_ff, fr_in;
   logic [63:0]       w_ff, w_in;
   logic [31:0]       g_ff, g_in;
   logic [31:0]       mag1_ff, mag1_in;
   logic [31:0]       mag2_ff, mag2_in;
   logic [NORM_W-1:0] out1_ff, out1_in;
   logic [NORM_W-1:0] out2_ff, out2_in;
   logic [STAT_W-1:0] outs_ff, outs_in;

   logic [3:0]  k_calc;
   logic [63:0] dd_pow, rr_pow, den_pow;
   logic [30:0] two_x1, two_x2, dd31;
   logic        na_c, nb_c;
   logic [30:0] aa_c, ab_c;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [36:0] l_val;
   logic [31:0] yy;
   logic [63:0] mag_shifted;
   logic [31:0] mag_sat;

   logic        div_start, div_done;
   logic [63:0] div_rinit, div_dvd, div_dsr, div_q, div_r;
   logic [5:0]  div_cnt;
   logic        sqrt_start, sqrt_done;
   logic [63:0] sqrt_val;
   logic [31:0] sqrt_root;

   assign k_calc = digit_count(seed_ff);

   // D = 10^k, R = 10^(k/2), D^2 = 10^(2k)
   assign dd_pow  = pow10({1'b0, k_calc});
   assign rr_pow  = pow10({2'd0, k_calc[3:1]});
   assign den_pow = pow10({k_calc, 1'b0});

   // a = 2x - D as sign and magnitude
   assign two_x1 = {x1_ff, 1'b0};
   assign two_x2 = {x2_ff, 1'b0};
   assign dd31   = {1'b0, dd_ff};
   assign na_c   = two_x1 < dd31;
   assign nb_c   = two_x2 < dd31;
   assign aa_c   = na_c ? dd31 - two_x1 : two_x1 - dd31;
   assign ab_c   = nb_c ? dd31 - two_x2 : two_x2 - dd31;

   // -log2 s in Q.30
   assign l_val = {1'b0, e_ff, 30'd0} + 37'h0_4000_0000 - {6'd0, fr_ff};
   assign yy    = prod_ff[61:30];

   assign mag_shifted = prod_ff >> MAG_SHIFT;
   assign mag_sat     = (mag_shifted > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_shifted[31:0];

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (cmd.op)
         OP_SQX:    begin mul_a = {2'd0, x2_ff}; mul_b = {2'd0, x2_ff}; end
         OP_SQA:    begin mul_a = {2'd0, aa_ff}; mul_b = {2'd0, aa_ff}; end
         OP_SQB:    begin mul_a = {2'd0, ab_ff}; mul_b = {2'd0, ab_ff}; end
         OP_LOGSQ:  begin mul_a = {1'b0, y_ff}; mul_b = {1'b0, y_ff}; end
         OP_WLO:    begin mul_a = {2'd0, l_val[29:0]}; mul_b = {1'b0, TWO_LN2_Q30}; end
         OP_WHI:    begin mul_a = {25'd0, l_val[36:30]}; mul_b = {1'b0, TWO_LN2_Q30}; end
         OP_MUL_C:  begin mul_a = g_ff; mul_b = sqrt_root; end
         default:   begin mul_a = 32'd0; mul_b = 32'd0; end
      endcase
   end

   always_comb begin
      div_rinit = 64'd0;
      div_dvd   = 64'd0;
      div_dsr   = 64'd1;
      div_cnt   = 6'(INT_DIV_STEPS);
      unique case (cmd.op)
         OP_DIV_R: begin
            div_dvd = {prod_ff[59:0], 4'd0};
            div_dsr = {50'd0, rr_ff};
         end
         OP_DIV_D: begin
            div_dvd = {div_q[59:0], 4'd0};
            div_dsr = {34'd0, dd_ff};
         end
         OP_DIV_M: begin
            div_rinit = {3'd0, n_ff};
            div_dsr   = {4'd0, den_ff};
            div_cnt   = 6'(LOG_STEPS);
         end
         OP_DIV_A: begin
            div_rinit = {4'd0, sa_ff};
            div_dsr   = {3'd0, num_ff};
            div_cnt   = 6'(RATIO_BITS);
         end
         OP_DIV_B: begin
            div_rinit = {4'd0, sb_ff};
            div_dsr   = {3'd0, num_ff};
            div_cnt   = 6'(RATIO_BITS);
         end
         default: begin
            div_rinit = 64'd0;
         end
      endcase
   end

   assign div_start = (cmd.op == OP_DIV_R) || (cmd.op == OP_DIV_D) || (cmd.op == OP_DIV_M)
                   || (cmd.op == OP_DIV_A) || (cmd.op == OP_DIV_B);
   assign sqrt_start = (cmd.op == OP_SQRT_W) || (cmd.op == OP_SQRT_C);
   assign sqrt_val   = (cmd.op == OP_SQRT_W) ? w_ff : div_q;

   always_comb begin
      seed_in = seed_ff;
      dd_in   = dd_ff;
      rr_in   = rr_ff;
      den_in  = den_ff;
      x1_in   = x1_ff;
      x2_in   = x2_ff;
      aa_in   = aa_ff;
      ab_in   = ab_ff;
      na_in   = na_ff;
      nb_in   = nb_ff;
      prod_in = prod_ff;
      sa_in   = sa_ff;
      sb_in   = sb_ff;
      num_in  = num_ff;
      n_in    = n_ff;
      e_in    = e_ff;
      y_in    = y_ff;
      fr_in   = fr_ff;
      w_in    = w_ff;
      g_in    = g_ff;
      mag1_in = mag1_ff;
      mag2_in = mag2_ff;
      out1_in = out1_ff;
      out2_in = out2_ff;
      outs_in = outs_ff;
      unique case (cmd.op)
         OP_LOAD: seed_in = req_seed;
         OP_SETUP: begin
            dd_in  = dd_pow[29:0];
            rr_in  = rr_pow[13:0];
            den_in = den_pow[59:0];
            x2_in  = {3'd0, seed_ff};
         end
         OP_SQX: begin
            prod_in = mul_p;
            x1_in   = x2_ff;
         end
         OP_TAKE_X: x2_in = div_r[29:0];
         OP_ABS: begin
            aa_in = aa_c[29:0];
            ab_in = ab_c[29:0];
            na_in = na_c;
            nb_in = nb_c;
         end
         OP_SQA: prod_in = mul_p;
         OP_SQB: begin
            sa_in   = prod_ff[59:0];
            prod_in = mul_p;
         end
         OP_SUM: begin
            sb_in  = prod_ff[59:0];
            num_in = {1'b0, sa_ff} + {1'b0, prod_ff[59:0]};
         end
         OP_CHK: begin
            n_in = num_ff;
            e_in = 6'd0;
         end
         OP_NORM: begin
            if (!stat.norm_done) begin
               n_in = {n_ff[59:0], 1'b0};
               e_in = e_ff + 6'd1;
            end
         end
         OP_LOGINIT: begin
            y_in  = {div_q[29:0], 1'b0};
            fr_in = stat.m_one ? 31'h4000_0000 : 31'd0;
         end
         OP_LOGSQ: prod_in = mul_p;
         OP_LOGUPD: begin
            // a square of two or more sets the next log bit and halves
            y_in  = yy[31] ? yy[31:1] : yy[30:0];
            fr_in = {fr_ff[29:0], yy[31]};
         end
         OP_WLO: prod_in = mul_p;
         OP_WHI: begin
            w_in    = {4'd0, prod_ff[63:4]};
            prod_in = mul_p;
         end
         OP_WSUM: w_in = w_ff + {prod_ff[37:0], 26'd0};
         OP_TAKE_G: g_in = sqrt_root;
         OP_MUL_C: prod_in = mul_p;
         OP_MAG_A: mag1_in = na_ff ? (~mag_sat + 32'd1) : mag_sat;
         OP_MAG_B: mag2_in = nb_ff ? (~mag_sat + 32'd1) : mag_sat;
         OP_PUBLISH: begin
            outs_in = cmd.code;
            out1_in = (cmd.code == ST_OK) ? mag1_ff : '0;
            out2_in = (cmd.code == ST_OK) ? mag2_ff : '0;
         end
         default: begin
            seed_in = seed_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
      dd_ff   <= dd_in;
      rr_ff   <= rr_in;
      den_ff  <= den_in;
      x1_ff   <= x1_in;
      x2_ff   <= x2_in;
      aa_ff   <= aa_in;
      ab_ff   <= ab_in;
      na_ff   <= na_in;
      nb_ff   <= nb_in;
      prod_ff <= prod_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      num_ff  <= num_in;
      n_ff    <= n_in;
      e_ff    <= e_in;
      y_ff    <= y_in;
      fr_ff   <= fr_in;
      w_ff    <= w_in;
      g_ff    <= g_in;
      mag1_ff <= mag1_in;
      mag2_ff <= mag2_in;
      out1_ff <= out1_in;
      out2_ff <= out2_in;
      outs_ff <= outs_in;
   end

   assign stat.seed_bad  = (seed_ff < 27'd10) || (int'(k_calc) > MAX_DIGITS);
   assign stat.accept    = (num_ff != 61'd0) && (num_ff <= {1'b0, den_ff});
   assign stat.norm_done = {n_ff, 1'b0} > {2'd0, den_ff};
   assign stat.m_one     = div_q[30:0] == 31'h4000_0000;
   assign stat.div_done  = div_done;
   assign stat.sqrt_done = sqrt_done;

   assign rsp_first_normal  = out1_ff;
   assign rsp_second_normal = out2_ff;
   assign rsp_status        = outs_ff;

   pgg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rinit),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .count    (div_cnt),
      .quo      (div_q),
      .rem      (div_r),
      .done     (div_done)
   );

   pgg_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_val),
      .root  (sqrt_root),
      .done  (sqrt_done)
   );

endmodule

// ===== hdl/pgg_ctrl.sv =====
// Controller: sequences the datapath through seeding, tries, log, roots and result hand-off.
module pgg_ctrl
   import pgg_pkg::*;
#(
   parameter int MAX_TRIES = 1000
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  pgg_stat_type stat,
   output pgg_cmd_type  cmd
);

   localparam logic [5:0] S_IDLE    = 6'd0;
   localparam logic [5:0] S_SETUP   = 6'd1;
   localparam logic [5:0] S_SQX     = 6'd2;
   localparam logic [5:0] S_DIVR    = 6'd3;
   localparam logic [5:0] S_DIVR_W  = 6'd4;
   localparam logic [5:0] S_DIVD    = 6'd5;
   localparam logic [5:0] S_DIVD_W  = 6'd6;
   localparam logic [5:0] S_TAKEX   = 6'd7;
   localparam logic [5:0] S_ABS     = 6'd8;
   localparam logic [5:0] S_SQA     = 6'd9;
   localparam logic [5:0] S_SQB     = 6'd10;
   localparam logic [5:0] S_SUM     = 6'd11;
   localparam logic [5:0] S_CHK     = 6'd12;
   localparam logic [5:0] S_NORM    = 6'd13;
   localparam logic [5:0] S_DIVM    = 6'd14;
   localparam logic [5:0] S_DIVM_W  = 6'd15;
   localparam logic [5:0] S_LOGINIT = 6'd16;
   localparam logic [5:0] S_LOGSQ   = 6'd17;
   localparam logic [5:0] S_LOGUPD  = 6'd18;
   localparam logic [5:0] S_WLO     = 6'd19;
   localparam logic [5:0] S_WHI     = 6'd20;
   localparam logic [5:0] S_WSUM    = 6'd21;
   localparam logic [5:0] S_SQRTW   = 6'd22;
   localparam logic [5:0] S_SQRTW_W = 6'd23;
   localparam logic [5:0] S_TAKEG   = 6'd24;
   localparam logic [5:0] S_DIVA    = 6'd25;
   localparam logic [5:0] S_DIVA_W  = 6'd26;
   localparam logic [5:0] S_SQRTA   = 6'd27;
   localparam logic [5:0] S_SQRTA_W = 6'd28;
   localparam logic [5:0] S_MULA    = 6'd29;
   localparam logic [5:0] S_MAGA    = 6'd30;
   localparam logic [5:0] S_DIVB    = 6'd31;
   localparam logic [5:0] S_DIVB_W  = 6'd32;
   localparam logic [5:0] S_SQRTB   = 6'd33;
   localparam logic [5:0] S_SQRTB_W = 6'd34;
   localparam logic [5:0] S_MULB    = 6'd35;
   localparam logic [5:0] S_MAGB    = 6'd36;
   localparam logic [5:0] S_FIN     = 6'd37;

   logic [5:0]        state_ff, state_in;
   logic              warm_ff, warm_in;
   logic [TRY_W-1:0]  try_ff, try_in;
   logic [4:0]        iter_ff, iter_in;
   logic [STAT_W-1:0] code_ff, code_in;
   logic              valid_ff, valid_in;
   logic              slot_free;

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      warm_in  = warm_ff;
      try_in   = try_ff;
      iter_in  = iter_ff;
      code_in  = code_ff;
      valid_in = valid_ff && rsp_stall;
      cmd.op   = OP_NONE;
      cmd.code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.op  = OP_SETUP;
            warm_in = 1'b0;
            try_in  = '0;
            if (stat.seed_bad) begin
               code_in  = ST_RANGE;
               state_in = S_FIN;
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            cmd.op   = OP_SQX;
            state_in = S_DIVR;
         end
         S_DIVR: begin
            cmd.op   = OP_DIV_R;
            state_in = S_DIVR_W;
         end
         S_DIVR_W: if (stat.div_done) state_in = S_DIVD;
         S_DIVD: begin
            cmd.op   = OP_DIV_D;
            state_in = S_DIVD_W;
         end
         S_DIVD_W: if (stat.div_done) state_in = S_TAKEX;
         S_TAKEX: begin
            cmd.op = OP_TAKE_X;
            if (!warm_ff) begin
               warm_in  = 1'b1;
               state_in = S_SQX;
            end else begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            cmd.op   = OP_ABS;
            state_in = S_SQA;
         end
         S_SQA: begin
            cmd.op   = OP_SQA;
            state_in = S_SQB;
         end
         S_SQB: begin
            cmd.op   = OP_SQB;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op   = OP_SUM;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.op = OP_CHK;
            if (stat.accept) begin
               state_in = S_NORM;
            end else if (try_ff == TRY_W'(MAX_TRIES - 1)) begin
               code_in  = ST_FAIL;
               state_in = S_FIN;
            end else begin
               try_in   = try_ff + 1'b1;
               state_in = S_SQX;
            end
         end
         S_NORM: begin
            cmd.op = OP_NORM;
            if (stat.norm_done) state_in = S_DIVM;
         end
         S_DIVM: begin
            cmd.op   = OP_DIV_M;
            state_in = S_DIVM_W;
         end
         S_DIVM_W: if (stat.div_done) state_in = S_LOGINIT;
         S_LOGINIT: begin
            cmd.op  = OP_LOGINIT;
            iter_in = 5'd0;
            state_in = stat.m_one ? S_WLO : S_LOGSQ;
         end
         S_LOGSQ: begin
            cmd.op   = OP_LOGSQ;
            state_in = S_LOGUPD;
         end
         S_LOGUPD: begin
            cmd.op = OP_LOGUPD;
            if (iter_ff == 5'(LOG_STEPS - 1)) begin
               state_in = S_WLO;
            end else begin
               iter_in  = iter_ff + 5'd1;
               state_in = S_LOGSQ;
            end
         end
         S_WLO: begin
            cmd.op   = OP_WLO;
            state_in = S_WHI;
         end
         S_WHI: begin
            cmd.op   = OP_WHI;
            state_in = S_WSUM;
         end
         S_WSUM: begin
            cmd.op   = OP_WSUM;
            state_in = S_SQRTW;
         end
         S_SQRTW: begin
            cmd.op   = OP_SQRT_W;
            state_in = S_SQRTW_W;
         end
         S_SQRTW_W: if (stat.sqrt_done) state_in = S_TAKEG;
         S_TAKEG: begin
            cmd.op   = OP_TAKE_G;
            state_in = S_DIVA;
         end
         S_DIVA: begin
            cmd.op   = OP_DIV_A;
            state_in = S_DIVA_W;
         end
         S_DIVA_W: if (stat.div_done) state_in = S_SQRTA;
         S_SQRTA: begin
            cmd.op   = OP_SQRT_C;
            state_in = S_SQRTA_W;
         end
         S_SQRTA_W: if (stat.sqrt_done) state_in = S_MULA;
         S_MULA: begin
            cmd.op   = OP_MUL_C;
            state_in = S_MAGA;
         end
         S_MAGA: begin
            cmd.op   = OP_MAG_A;
            state_in = S_DIVB;
         end
         S_DIVB: begin
            cmd.op   = OP_DIV_B;
            state_in = S_DIVB_W;
         end
         S_DIVB_W: if (stat.div_done) state_in = S_SQRTB;
         S_SQRTB: begin
            cmd.op   = OP_SQRT_C;
            state_in = S_SQRTB_W;
         end
         S_SQRTB_W: if (stat.sqrt_done) state_in = S_MULB;
         S_MULB: begin
            cmd.op   = OP_MUL_C;
            state_in = S_MAGB;
         end
         S_MAGB: begin
            cmd.op   = OP_MAG_B;
            code_in  = ST_OK;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.op   = OP_PUBLISH;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      warm_ff <= warm_in;
      try_ff  <= try_in;
      iter_ff <= iter_in;
      code_ff <= code_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

endmodule
